[rtl/core/beg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beg_pkg
// Shared types, widths and codes of the battery energy gauge.
// ----------------------------------------------------------------------------
package beg_pkg;

	// field widths
	localparam int CurW    = 16;
	localparam int PowW    = 24;
	localparam int ScaleW  = 16;
	localparam int CapW    = 20;
	localparam int EnergyW = 48;
	localparam int FracW   = 24;
	localparam int FullW   = CapW + FracW;
	localparam int ProdW   = PowW + ScaleW;
	localparam int PctW    = 7;
	localparam int QuotW   = 7;
	localparam int NumW    = FullW + QuotW;
	localparam int CfgW    = CapW;

	// configuration register indexes
	localparam logic CFG_FULL_CAP   = 1'b0;
	localparam logic CFG_STEP_SCALE = 1'b1;

	localparam logic [CapW-1:0]   FULL_CAP_RST   = CapW'(200000);
	localparam logic [ScaleW-1:0] STEP_SCALE_RST = ScaleW'(2359);

	// current at or below -100 mA counts as charging
	localparam logic signed [CurW-1:0] CHARGE_THRESHOLD = -16'sd334;

	localparam logic [PctW-1:0] PCT_MIN = 7'd1;
	localparam logic [PctW-1:0] PCT_MAX = 7'd100;

	localparam logic signed [EnergyW-1:0] ENERGY_MAX = {1'b0, {(EnergyW-1){1'b1}}};
	localparam logic signed [EnergyW-1:0] ENERGY_MIN = {1'b1, {(EnergyW-1){1'b0}}};

	typedef enum logic [1:0] {
		GS_OK    = 2'd0,
		GS_CHG   = 2'd1,
		GS_EOC   = 2'd2,
		GS_FAULT = 2'd3
	} gauge_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_PCT,
		ST_DIV,
		ST_DONE
	} fsm_t;

endpackage

[rtl/core/beg_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beg_mul
// Serial multiplier: one bit of the scale per cycle, msb first.
// ----------------------------------------------------------------------------
module beg_mul (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [beg_pkg::PowW-1:0]         mcand,
	input  logic [beg_pkg::ScaleW-1:0]       mplr,
	output logic                             done,
	output logic [beg_pkg::ProdW-1:0]        prod
);

	logic                             busy_q;
	logic                             done_q;
	logic [$clog2(beg_pkg::ScaleW)-1:0] cnt_q;
	logic [beg_pkg::ProdW-1:0]        acc_q;
	logic [beg_pkg::PowW-1:0]         mcand_q;
	logic [beg_pkg::ScaleW-1:0]       mplr_q;
	logic [beg_pkg::ProdW-1:0]        addend;

	assign addend = mplr_q[beg_pkg::ScaleW-1] ?
		{{beg_pkg::ScaleW{1'b0}}, mcand_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $clog2(beg_pkg::ScaleW)'(beg_pkg::ScaleW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= '0;
			mcand_q <= mcand;
			mplr_q  <= mplr;
		end else if (busy_q) begin
			acc_q  <= {acc_q[beg_pkg::ProdW-2:0], 1'b0} + addend;
			mplr_q <= {mplr_q[beg_pkg::ScaleW-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

[rtl/core/beg_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beg_div
// Restoring divider for the percent: floor(energy * 100 / full), one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module beg_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [beg_pkg::FullW-1:0]    energy,
	input  logic [beg_pkg::FullW-1:0]    full,
	output logic                         done,
	output logic [beg_pkg::QuotW-1:0]    quot
);

	logic                                 busy_q;
	logic                                 done_q;
	logic [$clog2(beg_pkg::QuotW)-1:0]    cnt_q;
	logic [beg_pkg::NumW-1:0]             rem_q;
	logic [beg_pkg::NumW-1:0]             den_q;
	logic [beg_pkg::QuotW-1:0]            quot_q;
	logic [beg_pkg::NumW-1:0]             num100;
	logic                                 ge;

	// energy * 100 = energy * (64 + 32 + 4)
	assign num100 = {energy, 6'b0}
		+ {1'b0, energy, 5'b0}
		+ {4'b0, energy, 2'b0} + {1'b0, {beg_pkg::NumW-1{1'b0}}};

	assign ge = (rem_q >= den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $clog2(beg_pkg::QuotW)'(beg_pkg::QuotW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num100;
			den_q  <= {1'b0, full, {(beg_pkg::QuotW-1){1'b0}}};
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - den_q;
			end
			den_q  <= {1'b0, den_q[beg_pkg::NumW-1:1]};
			quot_q <= {quot_q[beg_pkg::QuotW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

[rtl/core/battery_energy_gauge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_energy_gauge
// Coulomb counting fuel gauge. Each request carries a current and a power
// reading; the gauge adds or subtracts power times the step scale to the
// remaining energy (2^-24 mWh units, saturating 48-bit signed), tracks the
// discharge, charge, end-of-charge and fault states and reports the charge
// percent 1..100. One request is worked on at a time: after a request is
// taken, the bit-serial step multiplier, the energy update, the restoring
// percent divider and the output register follow in turn. The next request
// is taken as soon as the previous result sits in the output register.
// ----------------------------------------------------------------------------
module battery_energy_gauge (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] current_raw, [39:16] power_raw, [40] store_enable,
	// [41] battery_fault, [47:42] zero
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [6:0] charge_percent, [8:7] battery_state, [56:9] remaining_energy,
	// [57] store_request, [63:58] zero
	output logic [63:0] m_tdata
);

	beg_pkg::fsm_t state_q, state_nxt;

	logic [beg_pkg::CapW-1:0]           fcap_q;
	logic [beg_pkg::ScaleW-1:0]         scale_q;
	logic signed [beg_pkg::EnergyW-1:0] energy_q;
	beg_pkg::gauge_state_t              gstate_q;
	logic                               lastneg_q;

	logic signed [beg_pkg::CurW-1:0]    cur_q;
	logic                               store_en_q;
	logic                               fault_q;
	logic                               store_req_q;

	logic                               m_tvalid_q;
	logic [beg_pkg::PctW-1:0]           pct_q;
	beg_pkg::gauge_state_t              out_state_q;
	logic [beg_pkg::EnergyW-1:0]        out_energy_q;
	logic                               out_store_q;

	logic                               accept;
	logic                               mul_start, mul_done;
	logic                               upd_en, div_start, div_done, out_load;
	logic [beg_pkg::ProdW-1:0]          prod;
	logic [beg_pkg::QuotW-1:0]          quot;

	logic [beg_pkg::FullW-1:0]          full_w;
	logic [23:0]                        fcap10;
	logic [beg_pkg::EnergyW-1:0]        full10;
	logic                               below_limit;
	logic                               is_dis, is_chg, is_eoc;
	beg_pkg::gauge_state_t              st0, gstate_nxt;
	logic signed [beg_pkg::EnergyW:0]   sum;
	logic signed [beg_pkg::EnergyW-1:0] sat, energy_nxt;
	logic                               store_nxt;
	logic                               e_pos, e_lt_full;
	logic [beg_pkg::PctW-1:0]           pct_nxt;

	assign accept = s_tvalid && s_tready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			beg_pkg::ST_IDLE: if (accept) state_nxt = beg_pkg::ST_MUL;
			beg_pkg::ST_MUL:  if (mul_done) state_nxt = beg_pkg::ST_UPD;
			beg_pkg::ST_UPD:  state_nxt = beg_pkg::ST_PCT;
			beg_pkg::ST_PCT:  state_nxt = beg_pkg::ST_DIV;
			beg_pkg::ST_DIV:  if (div_done) state_nxt = beg_pkg::ST_DONE;
			beg_pkg::ST_DONE: if (!m_tvalid_q || m_tready) state_nxt = beg_pkg::ST_IDLE;
			default:          state_nxt = beg_pkg::ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		s_tready  = (state_q == beg_pkg::ST_IDLE);
		mul_start = (state_q == beg_pkg::ST_IDLE) && s_tvalid;
		upd_en    = (state_q == beg_pkg::ST_UPD);
		div_start = (state_q == beg_pkg::ST_PCT);
		out_load  = (state_q == beg_pkg::ST_DONE) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= beg_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcap_q  <= beg_pkg::FULL_CAP_RST;
			scale_q <= beg_pkg::STEP_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				beg_pkg::CFG_FULL_CAP:   fcap_q  <= cfg_data;
				beg_pkg::CFG_STEP_SCALE: scale_q <= cfg_data[beg_pkg::ScaleW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q      <= s_tdata[15:0];
			store_en_q <= s_tdata[40];
			fault_q    <= s_tdata[41];
		end
	end

	beg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (s_tdata[39:16]),
		.mplr   (scale_q),
		.done   (mul_done),
		.prod   (prod)
	);

	// energy and state update
	assign full_w = {fcap_q, {beg_pkg::FracW{1'b0}}};
	assign fcap10 = {4'b0, fcap_q} * 24'd10;
	assign full10 = {fcap10, {beg_pkg::FracW{1'b0}}};
	assign below_limit = energy_q[beg_pkg::EnergyW-1]
		|| ({1'b0, energy_q[beg_pkg::EnergyW-2:0]} < full10);

	always_comb begin
		st0 = fault_q ? beg_pkg::GS_FAULT
			: (gstate_q == beg_pkg::GS_FAULT ? beg_pkg::GS_OK : gstate_q);
		is_dis = !cur_q[beg_pkg::CurW-1] && (cur_q != '0);
		is_chg = (cur_q <= beg_pkg::CHARGE_THRESHOLD);
		is_eoc = !is_dis && !is_chg && store_en_q && (st0 != beg_pkg::GS_EOC) && lastneg_q;

		if (is_dis) begin
			sum = {energy_q[beg_pkg::EnergyW-1], energy_q} - {9'b0, prod};
		end else begin
			sum = {energy_q[beg_pkg::EnergyW-1], energy_q} + {9'b0, prod};
		end
		if (sum[beg_pkg::EnergyW] != sum[beg_pkg::EnergyW-1]) begin
			sat = sum[beg_pkg::EnergyW] ? beg_pkg::ENERGY_MIN : beg_pkg::ENERGY_MAX;
		end else begin
			sat = sum[beg_pkg::EnergyW-1:0];
		end

		energy_nxt = energy_q;
		gstate_nxt = st0;
		store_nxt  = 1'b0;
		if (is_dis || is_chg) begin
			if (st0 != beg_pkg::GS_FAULT) begin
				gstate_nxt = is_dis ? beg_pkg::GS_OK : beg_pkg::GS_CHG;
			end
			if (below_limit) begin
				energy_nxt = sat;
			end
			store_nxt = store_en_q;
		end else if (is_eoc) begin
			energy_nxt = {4'b0, full_w};
			gstate_nxt = beg_pkg::GS_EOC;
			store_nxt  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q  <= '0;
			gstate_q  <= beg_pkg::GS_OK;
			lastneg_q <= 1'b0;
		end else if (upd_en) begin
			energy_q  <= energy_nxt;
			gstate_q  <= gstate_nxt;
			lastneg_q <= cur_q[beg_pkg::CurW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en) begin
			store_req_q <= store_nxt;
		end
	end

	beg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.energy (energy_q[beg_pkg::FullW-1:0]),
		.full   (full_w),
		.done   (div_done),
		.quot   (quot)
	);

	// percent: divider result only used for 0 < energy < full
	assign e_pos     = !energy_q[beg_pkg::EnergyW-1] && (energy_q != '0);
	assign e_lt_full = energy_q[beg_pkg::EnergyW-1]
		|| (energy_q[beg_pkg::EnergyW-2:0] < {3'b0, full_w});

	always_comb begin
		if (e_pos && e_lt_full) begin
			pct_nxt = quot + 1'b1;
		end else if (!e_lt_full) begin
			pct_nxt = beg_pkg::PCT_MAX;
		end else begin
			pct_nxt = beg_pkg::PCT_MIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pct_q        <= pct_nxt;
			out_state_q  <= gstate_q;
			out_energy_q <= energy_q;
			out_store_q  <= store_req_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, out_store_q, out_energy_q, out_state_q, pct_q};

	// the serial units only finish in the state that waits for them
	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == beg_pkg::ST_MUL)
		else $error("multiplier finished outside its wait state");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == beg_pkg::ST_DIV)
		else $error("divider finished outside its wait state");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (pct_q >= beg_pkg::PCT_MIN) && (pct_q <= beg_pkg::PCT_MAX))
		else $error("charge percent out of range");

	a_eoc_store: assert property (@(posedge clk) disable iff (!arst_n)
		upd_en && is_eoc |=> gstate_q == beg_pkg::GS_EOC && store_req_q)
		else $error("end of charge without store request");

endmodule
